### hdl/i2cm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared constants and codes of the byte-level I2C master sequencer.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int BUF_DEPTH = 32;
  localparam int AW        = $clog2(BUF_DEPTH);
  localparam int CW        = $clog2(BUF_DEPTH + 1);

  localparam logic [7:0] ADDR_WR_MASK = 8'hFE;
  localparam logic [7:0] ADDR_RD_BIT  = 8'h01;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_START_W = 2'd1,
    ACT_START_R = 2'd2,
    ACT_EVENT   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESTART = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_WRITE   = 3'd4,
    CMD_RCEN    = 3'd5,
    CMD_ACK     = 3'd6,
    CMD_NACK    = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    NT_NONE      = 3'd0,
    NT_ACCEPTED  = 3'd1,
    NT_BUSY      = 3'd2,
    NT_SEND_DONE = 3'd3,
    NT_SEND_FAIL = 3'd4,
    NT_READ_DONE = 3'd5,
    NT_READ_FAIL = 3'd6
  } notice_t;

  typedef enum logic [9:0] {
    PH_IDLE       = 10'b00_0000_0001,
    PH_SEND_START = 10'b00_0000_0010,
    PH_SEND       = 10'b00_0000_0100,
    PH_READ_START = 10'b00_0000_1000,
    PH_ADDR_ACK   = 10'b00_0001_0000,
    PH_CMD_ACK    = 10'b00_0010_0000,
    PH_RESTARTED  = 10'b00_0100_0000,
    PH_RADDR_ACK  = 10'b00_1000_0000,
    PH_RECV       = 10'b01_0000_0000,
    PH_RECV_ACK   = 10'b10_0000_0000
  } phase_t;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001,
    C_EXEC = 4'b0010,
    C_BRD  = 4'b0100,
    C_BOUT = 4'b1000
  } ctl_t;

endpackage
`default_nettype wire

### hdl/i2c_master_transaction_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer
// Byte-level I2C master: write runs and register reads, at most one bus command per
// event, received bytes delivered as a run after a completed read.
// ----------------------------------------------------------------------------
// Timing: the accept cycle drives the transmit store read and registers the item;
//   the execute state registers the result once the output register is free.
// Items are taken only while idle; a read completion run then delivers each
//   received byte through the receive store's registered read port, before any new item.
// Reset: rst_n synchronous, clears phase, counts, pointers, target address
//   and handshake state; the byte stores are not cleared.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer
  import i2cm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_action,
  input  wire logic [4:0] in_byte_index,
  input  wire logic [7:0] in_data_byte,
  input  wire logic [5:0] in_xfer_length,
  input  wire logic       in_bus_busy,
  input  wire logic       in_ack_status,
  input  wire logic       in_byte_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      out_bus_command,
  output logic [7:0]      out_tx_byte,
  output logic [2:0]      out_notice,
  output logic [7:0]      out_read_data,
  output logic            out_data_valid,
  output logic            out_last
);

  ctl_t          ctl_r, ctl_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    target_r;
  logic [CW-1:0] tx_count_r, tx_count_nxt;
  logic [CW-1:0] tx_ptr_r, tx_ptr_nxt;
  logic [CW-1:0] rx_count_r, rx_count_nxt;
  logic [CW-1:0] rx_ptr_r, rx_ptr_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic          out_valid_r, out_valid_nxt;

  action_t       act_r;
  logic [4:0]    idx_r;
  logic [7:0]    dbyte_r;
  logic [5:0]    len_r;
  logic          busy_r, nack_r, rdy_r;
  logic [7:0]    rxb_r;

  logic [2:0]    cmd_r;
  logic [7:0]    txb_r;
  logic [2:0]    nt_r;
  logic [7:0]    rd_r;
  logic          dv_r, last_r;

  logic          tx_we, rx_we;
  logic [AW-1:0] tx_wa, tx_ra, rx_wa, rx_ra;
  logic [7:0]    tx_wd, tx_rd, rx_rd;

  logic          out_free, accept, exec_fire, bout_fire, burst_last;
  logic          has_res, burst_go;
  cmd_t          r_cmd;
  logic [7:0]    r_txb;
  notice_t       r_nt;
  logic [7:0]    wr_addr, rd_addr;
  logic [CW-1:0] sat_len;

  assign cfg_ready = 1'b1;
  assign in_ready  = (ctl_r == C_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign wr_addr   = target_r & ADDR_WR_MASK;
  assign rd_addr   = target_r | ADDR_RD_BIT;
  assign sat_len   = (32'(len_r) > BUF_DEPTH) ? CW'(BUF_DEPTH) : CW'(len_r);

  assign tx_ra = (phase_r == PH_ADDR_ACK) ? '0 : tx_ptr_r[AW-1:0];
  assign rx_ra = k_r[AW-1:0];

  i2cm_ram #(.DEPTH(BUF_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_wa),
    .wdata (tx_wd),
    .raddr (tx_ra),
    .rdata (tx_rd)
  );

  i2cm_ram #(.DEPTH(BUF_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_we),
    .waddr (rx_wa),
    .wdata (rxb_r),
    .raddr (rx_ra),
    .rdata (rx_rd)
  );

  // item execution
  always_comb begin
    has_res      = 1'b0;
    burst_go     = 1'b0;
    r_cmd        = CMD_NONE;
    r_txb        = '0;
    r_nt         = NT_NONE;
    phase_nxt    = phase_r;
    tx_count_nxt = tx_count_r;
    tx_ptr_nxt   = tx_ptr_r;
    rx_count_nxt = rx_count_r;
    rx_ptr_nxt   = rx_ptr_r;
    tx_we        = 1'b0;
    tx_wa        = idx_r[AW-1:0];
    tx_wd        = dbyte_r;
    rx_we        = 1'b0;
    rx_wa        = rx_ptr_r[AW-1:0];
    unique case (act_r) inside
      ACT_LOAD: begin
        tx_we = (32'(idx_r) < BUF_DEPTH);
      end
      ACT_START_W, ACT_START_R: begin
        has_res = 1'b1;
        if (busy_r || phase_r != PH_IDLE) begin
          r_nt = NT_BUSY;
        end else begin
          r_cmd = CMD_START;
          r_nt  = NT_ACCEPTED;
          tx_ptr_nxt = '0;
          if (act_r == ACT_START_W) begin
            tx_count_nxt = sat_len;
            phase_nxt    = PH_SEND_START;
          end else begin
            rx_count_nxt = sat_len;
            rx_ptr_nxt   = '0;
            tx_count_nxt = CW'(1);
            tx_we        = 1'b1;
            tx_wa        = '0;
            phase_nxt    = PH_READ_START;
          end
        end
      end
      default: begin
        unique case (phase_r) inside
          PH_SEND_START: begin
            has_res   = 1'b1;
            phase_nxt = PH_SEND;
            r_cmd     = CMD_WRITE;
            r_txb     = wr_addr;
          end
          PH_SEND: begin
            has_res = 1'b1;
            if (nack_r) begin
              phase_nxt = PH_IDLE;
              r_cmd     = CMD_STOP;
              r_nt      = NT_SEND_FAIL;
            end else if (tx_ptr_r < tx_count_r) begin
              r_cmd      = CMD_WRITE;
              r_txb      = tx_rd;
              tx_ptr_nxt = tx_ptr_r + CW'(1);
            end else begin
              phase_nxt    = PH_IDLE;
              tx_count_nxt = '0;
              r_cmd        = CMD_STOP;
              r_nt         = NT_SEND_DONE;
            end
          end
          PH_READ_START: begin
            has_res   = 1'b1;
            phase_nxt = PH_ADDR_ACK;
            r_cmd     = CMD_WRITE;
            r_txb     = wr_addr;
          end
          PH_ADDR_ACK, PH_CMD_ACK, PH_RADDR_ACK: begin
            has_res = 1'b1;
            if (nack_r) begin
              phase_nxt = PH_IDLE;
              r_cmd     = CMD_STOP;
              r_nt      = NT_READ_FAIL;
            end else if (phase_r == PH_ADDR_ACK) begin
              phase_nxt    = PH_CMD_ACK;
              tx_count_nxt = '0;
              r_cmd        = CMD_WRITE;
              r_txb        = tx_rd;
            end else if (phase_r == PH_CMD_ACK) begin
              phase_nxt = PH_RESTARTED;
              r_cmd     = CMD_RESTART;
            end else begin
              phase_nxt = PH_RECV;
              r_cmd     = CMD_RCEN;
            end
          end
          PH_RESTARTED: begin
            has_res   = 1'b1;
            phase_nxt = PH_RADDR_ACK;
            r_cmd     = CMD_WRITE;
            r_txb     = rd_addr;
          end
          PH_RECV: begin
            if (rdy_r) begin
              has_res   = 1'b1;
              rx_we     = (32'(rx_ptr_r) < BUF_DEPTH);
              phase_nxt = PH_RECV_ACK;
              if ((CW + 1)'(rx_ptr_r) + (CW + 1)'(1) < (CW + 1)'(rx_count_r)) begin
                rx_ptr_nxt = rx_ptr_r + CW'(1);
                r_cmd      = CMD_ACK;
              end else begin
                rx_ptr_nxt = rx_count_r;
                r_cmd      = CMD_NACK;
              end
            end
          end
          PH_RECV_ACK: begin
            if (rx_ptr_r < rx_count_r) begin
              has_res   = 1'b1;
              phase_nxt = PH_RECV;
              r_cmd     = CMD_RCEN;
            end else begin
              phase_nxt = PH_IDLE;
              if (rx_count_r == '0) begin
                has_res = 1'b1;
                r_cmd   = CMD_STOP;
                r_nt    = NT_READ_DONE;
              end else begin
                burst_go = 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    endcase
    exec_fire = (ctl_r == C_EXEC) && (!has_res || out_free);
    tx_we     = tx_we && exec_fire;
    rx_we     = rx_we && exec_fire;
  end

  assign bout_fire  = (ctl_r == C_BOUT) && out_free;
  assign burst_last = (k_r + CW'(1) == rx_count_r);

  always_comb begin
    ctl_nxt       = ctl_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (ctl_r)
      C_IDLE: begin
        if (accept) begin
          ctl_nxt = C_EXEC;
        end
      end
      C_EXEC: begin
        if (exec_fire) begin
          if (has_res) begin
            out_valid_nxt = 1'b1;
          end
          if (burst_go) begin
            k_nxt   = '0;
            ctl_nxt = C_BRD;
          end else begin
            ctl_nxt = C_IDLE;
          end
        end
      end
      C_BRD: begin
        ctl_nxt = C_BOUT;
      end
      C_BOUT: begin
        if (bout_fire) begin
          out_valid_nxt = 1'b1;
          if (burst_last) begin
            ctl_nxt = C_IDLE;
          end else begin
            k_nxt   = k_r + CW'(1);
            ctl_nxt = C_BRD;
          end
        end
      end
      default: begin
        ctl_nxt = C_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r       <= C_IDLE;
      phase_r     <= PH_IDLE;
      target_r    <= '0;
      tx_count_r  <= '0;
      tx_ptr_r    <= '0;
      rx_count_r  <= '0;
      rx_ptr_r    <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl_r       <= ctl_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        target_r <= cfg_data;
      end
      if (exec_fire) begin
        phase_r    <= phase_nxt;
        tx_count_r <= tx_count_nxt;
        tx_ptr_r   <= tx_ptr_nxt;
        rx_count_r <= rx_count_nxt;
        rx_ptr_r   <= rx_ptr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r   <= action_t'(in_action);
      idx_r   <= in_byte_index;
      dbyte_r <= in_data_byte;
      len_r   <= in_xfer_length;
      busy_r  <= in_bus_busy;
      nack_r  <= in_ack_status;
      rdy_r   <= in_byte_ready;
      rxb_r   <= in_rx_byte;
    end
    if (exec_fire && has_res) begin
      cmd_r  <= r_cmd;
      txb_r  <= r_txb;
      nt_r   <= r_nt;
      rd_r   <= '0;
      dv_r   <= 1'b0;
      last_r <= 1'b1;
    end else if (bout_fire) begin
      cmd_r  <= (k_r == '0) ? CMD_STOP : CMD_NONE;
      txb_r  <= '0;
      nt_r   <= (k_r == '0) ? NT_READ_DONE : NT_NONE;
      rd_r   <= rx_rd;
      dv_r   <= 1'b1;
      last_r <= burst_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_bus_command = cmd_r;
  assign out_tx_byte     = txb_r;
  assign out_notice      = nt_r;
  assign out_read_data   = rd_r;
  assign out_data_valid  = dv_r;
  assign out_last        = last_r;

endmodule
`default_nettype wire

### hdl/i2cm_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module i2cm_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### tb/sv/i2cm_seq_checker.sv
// ----------------------------------------------------------------------------
// i2cm_seq_checker
// Watches the configuration, input and result channels of the I2C master
// sequencer, keeps its own copy of the phase machine and byte stores, and
// compares every accepted result item with the oldest expected one.
// ----------------------------------------------------------------------------
module i2cm_seq_checker
  import i2cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] in_action,
  input  logic [4:0] in_byte_index,
  input  logic [7:0] in_data_byte,
  input  logic [5:0] in_xfer_length,
  input  logic       in_bus_busy,
  input  logic       in_ack_status,
  input  logic       in_byte_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [2:0] out_bus_command,
  input  logic [7:0] out_tx_byte,
  input  logic [2:0] out_notice,
  input  logic [7:0] out_read_data,
  input  logic       out_data_valid,
  input  logic       out_last,
  output int         mismatch_count,
  output int         pending
);

  typedef struct {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    notice_t    notice;
    logic [7:0] read_data;
    logic       data_valid;
    logic       last;
  } bus_result_t;

  bus_result_t expected_bus_results[$];

  phase_t     seq_phase;
  logic [7:0] target_addr;
  logic [7:0] tx_mem [BUF_DEPTH];
  logic [7:0] rx_mem [BUF_DEPTH];
  int         tx_len, tx_pos, rx_len, rx_pos;

  function automatic int clamp_len(input logic [5:0] len);
    return (int'(len) > BUF_DEPTH) ? BUF_DEPTH : int'(len);
  endfunction

  task automatic expect_result(input cmd_t c, input logic [7:0] txb, input notice_t nt,
                               input logic [7:0] rd, input logic dv, input logic lst);
    bus_result_t r;
    r.cmd        = c;
    r.tx_byte    = txb;
    r.notice     = nt;
    r.read_data  = rd;
    r.data_valid = dv;
    r.last       = lst;
    expected_bus_results.push_back(r);
  endtask

  task automatic expect_single(input cmd_t c, input logic [7:0] txb, input notice_t nt);
    expect_result(c, txb, nt, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic abort_read();
    seq_phase = PH_IDLE;
    expect_single(CMD_STOP, 8'h00, NT_READ_FAIL);
  endtask

  task automatic sequencer_event(input logic nack, input logic rdy, input logic [7:0] rxb);
    logic [7:0] wr_addr, rd_addr;
    int         k;
    wr_addr = target_addr & ADDR_WR_MASK;
    rd_addr = target_addr | ADDR_RD_BIT;
    case (seq_phase)
      PH_SEND_START: begin
        seq_phase = PH_SEND;
        expect_single(CMD_WRITE, wr_addr, NT_NONE);
      end
      PH_SEND: begin
        if (nack) begin
          seq_phase = PH_IDLE;
          expect_single(CMD_STOP, 8'h00, NT_SEND_FAIL);
        end else if (tx_pos < tx_len) begin
          expect_single(CMD_WRITE, tx_mem[tx_pos], NT_NONE);
          tx_pos++;
        end else begin
          seq_phase = PH_IDLE;
          tx_len    = 0;
          expect_single(CMD_STOP, 8'h00, NT_SEND_DONE);
        end
      end
      PH_READ_START: begin
        seq_phase = PH_ADDR_ACK;
        expect_single(CMD_WRITE, wr_addr, NT_NONE);
      end
      PH_ADDR_ACK: begin
        if (nack) abort_read();
        else begin
          seq_phase = PH_CMD_ACK;
          tx_len    = 0;
          expect_single(CMD_WRITE, tx_mem[0], NT_NONE);
        end
      end
      PH_CMD_ACK: begin
        if (nack) abort_read();
        else begin
          seq_phase = PH_RESTARTED;
          expect_single(CMD_RESTART, 8'h00, NT_NONE);
        end
      end
      PH_RESTARTED: begin
        seq_phase = PH_RADDR_ACK;
        expect_single(CMD_WRITE, rd_addr, NT_NONE);
      end
      PH_RADDR_ACK: begin
        if (nack) abort_read();
        else begin
          seq_phase = PH_RECV;
          expect_single(CMD_RCEN, 8'h00, NT_NONE);
        end
      end
      PH_RECV: begin
        if (rdy) begin
          rx_mem[rx_pos] = rxb;
          seq_phase      = PH_RECV_ACK;
          if (rx_pos + 1 < rx_len) begin
            rx_pos++;
            expect_single(CMD_ACK, 8'h00, NT_NONE);
          end else begin
            rx_pos = rx_len;
            expect_single(CMD_NACK, 8'h00, NT_NONE);
          end
        end
      end
      PH_RECV_ACK: begin
        if (rx_pos < rx_len) begin
          seq_phase = PH_RECV;
          expect_single(CMD_RCEN, 8'h00, NT_NONE);
        end else begin
          seq_phase = PH_IDLE;
          if (rx_len == 0) expect_single(CMD_STOP, 8'h00, NT_READ_DONE);
          else begin
            for (k = 0; k < rx_len; k++)
              expect_result((k == 0) ? CMD_STOP : CMD_NONE, 8'h00,
                            (k == 0) ? NT_READ_DONE : NT_NONE,
                            rx_mem[k], 1'b1, k == rx_len - 1);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic sequencer_step(input action_t act, input logic [4:0] idx,
                                input logic [7:0] db, input logic [5:0] len,
                                input logic busy, input logic nack, input logic rdy,
                                input logic [7:0] rxb);
    case (act) inside
      ACT_LOAD: tx_mem[idx] = db;
      ACT_START_W, ACT_START_R: begin
        if (busy || seq_phase != PH_IDLE) expect_single(CMD_NONE, 8'h00, NT_BUSY);
        else begin
          if (act == ACT_START_W) begin
            tx_len    = clamp_len(len);
            tx_pos    = 0;
            seq_phase = PH_SEND_START;
          end else begin
            rx_len    = clamp_len(len);
            rx_pos    = 0;
            tx_mem[0] = db;
            tx_len    = 1;
            tx_pos    = 0;
            seq_phase = PH_READ_START;
          end
          expect_single(CMD_START, 8'h00, NT_ACCEPTED);
        end
      end
      default: sequencer_event(nack, rdy, rxb);
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    bus_result_t e;
    if (expected_bus_results.size() == 0) begin
      report_mismatch($sformatf("result with none expected: command %0d notice %0d",
                                out_bus_command, out_notice));
      return;
    end
    e = expected_bus_results.pop_front();
    if (out_bus_command !== e.cmd)
      report_mismatch($sformatf("bus_command expected %0d got %0d", e.cmd, out_bus_command));
    if (out_tx_byte !== e.tx_byte)
      report_mismatch($sformatf("tx_byte expected %02h got %02h", e.tx_byte, out_tx_byte));
    if (out_notice !== e.notice)
      report_mismatch($sformatf("notice expected %0d got %0d", e.notice, out_notice));
    if (out_read_data !== e.read_data)
      report_mismatch($sformatf("read_data expected %02h got %02h", e.read_data,
                                out_read_data));
    if (out_data_valid !== e.data_valid)
      report_mismatch($sformatf("data_valid expected %0b got %0b", e.data_valid,
                                out_data_valid));
    if (out_last !== e.last)
      report_mismatch($sformatf("last expected %0b got %0b", e.last, out_last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_phase   = PH_IDLE;
      target_addr = 8'h00;
      tx_len      = 0;
      tx_pos      = 0;
      rx_len      = 0;
      rx_pos      = 0;
      expected_bus_results.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) target_addr = cfg_data;
      if (in_valid && in_ready)
        sequencer_step(action_t'(in_action), in_byte_index, in_data_byte, in_xfer_length,
                       in_bus_busy, in_ack_status, in_byte_ready, in_rx_byte);
    end
    pending = expected_bus_results.size();
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the I2C master sequencer with directed and random write runs,
// register reads and stray items, idling at random on both channels except in the second random pass;
// the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE      = 8;

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       cfg_valid      = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data       = 8'h00;
  logic       in_valid       = 1'b0;
  logic       in_ready;
  logic [1:0] in_action      = 2'd0;
  logic [4:0] in_byte_index  = 5'd0;
  logic [7:0] in_data_byte   = 8'h00;
  logic [5:0] in_xfer_length = 6'd0;
  logic       in_bus_busy    = 1'b0;
  logic       in_ack_status  = 1'b0;
  logic       in_byte_ready  = 1'b0;
  logic [7:0] in_rx_byte     = 8'h00;
  logic       out_valid;
  logic       out_ready      = 1'b0;
  logic [2:0] out_bus_command;
  logic [7:0] out_tx_byte;
  logic [2:0] out_notice;
  logic [7:0] out_read_data;
  logic       out_data_valid;
  logic       out_last;

  int mismatch_count;
  int pending;
  int cycle_count = 0;
  int items_sent  = 0;
  int in_gap_max  = 5;
  int out_gap_max = 5;

  always #6 clk = ~clk;

  i2c_master_transaction_sequencer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_byte_index   (in_byte_index),
    .in_data_byte    (in_data_byte),
    .in_xfer_length  (in_xfer_length),
    .in_bus_busy     (in_bus_busy),
    .in_ack_status   (in_ack_status),
    .in_byte_ready   (in_byte_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bus_command (out_bus_command),
    .out_tx_byte     (out_tx_byte),
    .out_notice      (out_notice),
    .out_read_data   (out_read_data),
    .out_data_valid  (out_data_valid),
    .out_last        (out_last)
  );

  i2cm_seq_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_byte_index   (in_byte_index),
    .in_data_byte    (in_data_byte),
    .in_xfer_length  (in_xfer_length),
    .in_bus_busy     (in_bus_busy),
    .in_ack_status   (in_ack_status),
    .in_byte_ready   (in_byte_ready),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_bus_command (out_bus_command),
    .out_tx_byte     (out_tx_byte),
    .out_notice      (out_notice),
    .out_read_data   (out_read_data),
    .out_data_valid  (out_data_valid),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .pending         (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL i2c_master_transaction_sequencer");
      $finish;
    end
  end

  // result side back-pressure
  initial begin : result_sink
    int gap;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, out_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic push_item(input action_t a, input logic [4:0] idx, input logic [7:0] db,
                           input logic [5:0] len, input logic busy, input logic nack,
                           input logic rdy, input logic [7:0] rxb);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= a;
    in_byte_index  <= idx;
    in_data_byte   <= db;
    in_xfer_length <= len;
    in_bus_busy    <= busy;
    in_ack_status  <= nack;
    in_byte_ready  <= rdy;
    in_rx_byte     <= rxb;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic load_tx(input logic [4:0] idx, input logic [7:0] db);
    push_item(ACT_LOAD, idx, db, 6'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
              8'($urandom));
  endtask

  task automatic start_xfer(input action_t a, input logic [7:0] db, input logic [5:0] len,
                            input logic busy);
    push_item(a, 5'($urandom), db, len, busy, 1'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic bus_event(input logic nack, input logic rdy, input logic [7:0] rxb);
    push_item(ACT_EVENT, 5'($urandom), 8'($urandom), 6'($urandom), 1'($urandom), nack, rdy,
              rxb);
  endtask

  function automatic logic rare_nack();
    return $urandom_range(0, 19) == 0;
  endfunction

  function automatic logic [5:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 6'($urandom_range(0, 4));
    if (r < 90) return 6'($urandom_range(5, 16));
    return 6'($urandom_range(17, 63));
  endfunction

  task automatic write_run();
    logic [5:0] len;
    int         n;
    len = pick_len();
    n   = (int'(len) > BUF_DEPTH) ? BUF_DEPTH : int'(len);
    if ($urandom_range(0, 3) == 0) load_tx(5'($urandom), 8'($urandom));
    start_xfer(ACT_START_W, 8'($urandom), len, $urandom_range(0, 9) == 0);
    repeat (n + 2) bus_event(rare_nack(), 1'($urandom), 8'($urandom));
  endtask

  task automatic read_run();
    logic [5:0] len;
    int         n;
    len = pick_len();
    n   = (int'(len) > BUF_DEPTH) ? BUF_DEPTH : int'(len);
    if (n == 0) n = 1;
    start_xfer(ACT_START_R, 8'($urandom), len, $urandom_range(0, 9) == 0);
    repeat (5) bus_event(rare_nack(), 1'($urandom), 8'($urandom));
    repeat (n) begin
      while ($urandom_range(0, 5) == 0) bus_event(1'($urandom), 1'b0, 8'($urandom));
      bus_event(1'($urandom), 1'b1, 8'($urandom));
      bus_event(1'($urandom), 1'($urandom), 8'($urandom));
    end
  endtask

  task automatic stray_item();
    push_item(action_t'($urandom_range(0, 3)), 5'($urandom), 8'($urandom), 6'($urandom),
              1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_target(input logic [7:0] value);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int         k, first;
    logic [7:0] targets [3];
    targets[0] = 8'h00;
    targets[1] = 8'($urandom);
    targets[2] = 8'($urandom) | 8'h01;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed
    write_target(8'hFF);
    load_tx(5'd0, 8'h00);
    load_tx(5'd31, 8'hFF);
    bus_event(1'b0, 1'b1, 8'h5A);                     // event while idle
    start_xfer(ACT_START_W, 8'h00, 6'd1, 1'b1);       // refused, bus busy
    start_xfer(ACT_START_W, 8'h00, 6'd1, 1'b0);
    repeat (3) bus_event(1'b0, 1'b0, 8'h00);
    start_xfer(ACT_START_R, 8'hFF, 6'd0, 1'b0);       // zero-length read
    repeat (5) bus_event(1'b0, 1'b0, 8'h00);
    bus_event(1'b1, 1'b0, 8'h00);                     // byte not ready
    bus_event(1'b0, 1'b1, 8'hFF);
    bus_event(1'b0, 1'b0, 8'h00);
    start_xfer(ACT_START_R, 8'hA5, 6'd1, 1'b0);
    bus_event(1'b0, 1'b0, 8'h00);
    start_xfer(ACT_START_W, 8'h00, 6'd1, 1'b0);       // refused, not idle
    bus_event(1'b1, 1'b0, 8'h00);                     // address nack
    start_xfer(ACT_START_W, 8'h00, 6'd1, 1'b0);
    bus_event(1'b0, 1'b0, 8'h00);
    bus_event(1'b1, 1'b0, 8'h00);                     // address nack on a write

    // random
    for (k = 0; k < 3; k++) begin
      write_target(targets[k]);
      in_gap_max  = (k == 1) ? 0 : 5;
      out_gap_max = (k == 0) ? 5 : 0;
      if (k == 2) out_gap_max = 5;
      if (k == 0) begin
        for (first = 0; first < BUF_DEPTH; first++) load_tx(5'(first), 8'($urandom));
      end
      first = items_sent;
      while (items_sent - first < 60) begin
        case ($urandom_range(0, 9)) inside
          [0:3]:   write_run();
          [4:7]:   read_run();
          default: stray_item();
        endcase
        if ($urandom_range(0, 11) == 0) drain();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && pending == 0)
      $display("PASS i2c_master_transaction_sequencer");
    else
      $display("FAIL i2c_master_transaction_sequencer");
    $finish;
  end

endmodule
